FILE: hdl/rtc_calendar_with_command_parser_defines.svh
// Assertion macros shared by the calendar blocks.
`ifndef RTC_CALENDAR_WITH_COMMAND_PARSER_DEFINES_SVH
`define RTC_CALENDAR_WITH_COMMAND_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rtcc_pkg.sv
`default_nettype none

package rtcc_pkg;

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_TIME_SET  = 3'd1,
        ST_BAD_TIME  = 3'd2,
        ST_DATE_SET  = 3'd3,
        ST_BAD_DATE  = 3'd4,
        ST_BAD_INPUT = 3'd5
    } t_status;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_BYTE = 1'b1;

    localparam logic [7:0] CHAR_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_CLOSE = 8'h5D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [7:0]  TPS_RESET   = 8'd10;
    localparam logic [5:0]  SEC_RESET   = 6'd10;
    localparam logic [5:0]  MIN_RESET   = 6'd45;
    localparam logic [4:0]  HOUR_RESET  = 5'd18;
    localparam logic [4:0]  DAY_RESET   = 5'd1;
    localparam logic [3:0]  MONTH_RESET = 4'd1;
    localparam logic [13:0] YEAR_RESET  = 14'd1971;
    localparam logic [15:0] YEAR_BCD_RESET = 16'h1971;

    localparam logic [5:0]  SEC_MAX   = 6'd59;
    localparam logic [5:0]  MIN_MAX   = 6'd59;
    localparam logic [4:0]  HOUR_MAX  = 5'd23;
    localparam logic [3:0]  MONTH_MAX = 4'd12;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;

    localparam logic [3:0] DIGITS_TIME = 4'd6;
    localparam logic [3:0] DIGITS_DATE = 4'd8;
    localparam logic [3:0] DIGITS_SAT  = 4'd15;

    // Calendar fields, seconds in the lowest bits.
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  min;
        logic [5:0]  sec;
    } t_cal;

    typedef struct packed {
        logic        time_ld;
        logic        date_ld;
        logic [4:0]  hour;
        logic [5:0]  min;
        logic [5:0]  sec;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [15:0] year_bcd;
    } t_load;

    function automatic logic is_leap_bcd(input logic [15:0] y);
        logic [4:0] low_mod;
        logic [4:0] cen_mod;
        logic       low_zero;
        low_mod  = {y[7:4], 1'b0} + {1'b0, y[3:0]};
        cen_mod  = {y[15:12], 1'b0} + {1'b0, y[11:8]};
        low_zero = (y[7:0] == 8'h00);
        return ((low_mod[1:0] == 2'd0) && !low_zero) || (low_zero && (cen_mod[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [6:0] bcd2_to_bin(input logic [7:0] b);
        logic [6:0] tens;
        tens = {3'b000, b[7:4]};
        return 7'(tens * 7'd10) + {3'b000, b[3:0]};
    endfunction

    function automatic logic [13:0] bcd4_to_bin(input logic [15:0] b);
        logic [13:0] th;
        logic [13:0] hu;
        logic [13:0] te;
        th = {10'd0, b[15:12]};
        hu = {10'd0, b[11:8]};
        te = {10'd0, b[7:4]};
        return 14'(th * 14'd1000) + 14'(hu * 14'd100) + 14'(te * 14'd10) + {10'd0, b[3:0]};
    endfunction

    function automatic logic [15:0] bcd4_inc(input logic [15:0] b);
        logic [15:0] r;
        logic        carry;
        r     = b;
        carry = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (carry) begin
                if (r[4*i +: 4] == 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = r[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rtcc_parser.sv
`default_nettype none

`include "rtc_calendar_with_command_parser_defines.svh"

module rtcc_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire logic             i_cmd,
    input  wire logic [7:0]       i_byte,
    output rtcc_pkg::t_load       o_load,
    output rtcc_pkg::t_status     o_status
);

    logic        r_in_frame;
    logic [3:0]  r_digits;
    logic [31:0] r_acc;
    logic        r_bad;

    logic        n_in_frame;
    logic [3:0]  n_digits;
    logic [31:0] n_acc;
    logic        n_bad;

    logic        is_digit;
    logic        six_ok;
    logic        time_bad;
    logic        eight_ok;
    logic        date_bad;
    logic [6:0]  day_v;
    logic [6:0]  mon_v;
    logic [6:0]  hour_v;
    logic [6:0]  min_v;
    logic [6:0]  sec_v;
    logic [4:0]  mlen;
    logic [3:0]  d7, d6, d5, d4, d3, d1;

    // The accumulator holds the frame digits as packed BCD, newest digit lowest.
    always_comb begin
        d7 = r_acc[31:28];
        d6 = r_acc[27:24];
        d5 = r_acc[23:20];
        d4 = r_acc[19:16];
        d3 = r_acc[15:12];
        d1 = r_acc[7:4];

        is_digit = (i_byte >= rtcc_pkg::CHAR_ZERO) && (i_byte <= rtcc_pkg::CHAR_NINE);

        six_ok   = (r_digits == rtcc_pkg::DIGITS_TIME) &&
                   ((d5 < 4'd2) || ((d5 == 4'd2) && (d4 < 4'd5)));
        time_bad = ((d5 == 4'd2) && (d4 > 4'd3)) || (d3 > 4'd5) || (d1 > 4'd5);

        eight_ok = (r_digits == rtcc_pkg::DIGITS_DATE) &&
                   ((d7 != 4'd0) || (d6 != 4'd0) || (d5 > 4'd2) ||
                    ((d5 == 4'd2) && ((d4 > 4'd5) ||
                                      ((d4 == 4'd5) && (r_acc[15:0] != 16'h0000)))));
        day_v    = rtcc_pkg::bcd2_to_bin(r_acc[31:24]);
        mon_v    = rtcc_pkg::bcd2_to_bin(r_acc[23:16]);
        hour_v   = rtcc_pkg::bcd2_to_bin(r_acc[23:16]);
        min_v    = rtcc_pkg::bcd2_to_bin(r_acc[15:8]);
        sec_v    = rtcc_pkg::bcd2_to_bin(r_acc[7:0]);
        mlen     = rtcc_pkg::month_len(mon_v[3:0], rtcc_pkg::is_leap_bcd(r_acc[15:0]));
        date_bad = (mon_v == 7'd0) || (mon_v > {3'b000, rtcc_pkg::MONTH_MAX}) ||
                   (day_v == 7'd0) || (day_v > {2'b00, mlen});

        n_in_frame = r_in_frame;
        n_digits   = r_digits;
        n_acc      = r_acc;
        n_bad      = r_bad;
        o_status   = rtcc_pkg::ST_NONE;

        o_load          = '0;
        o_load.hour     = hour_v[4:0];
        o_load.min      = min_v[5:0];
        o_load.sec      = sec_v[5:0];
        o_load.day      = day_v[4:0];
        o_load.month    = mon_v[3:0];
        o_load.year     = rtcc_pkg::bcd4_to_bin(r_acc[15:0]);
        o_load.year_bcd = r_acc[15:0];

        if (i_fire && (i_cmd == rtcc_pkg::CMD_BYTE)) begin
            if (i_byte == rtcc_pkg::CHAR_OPEN) begin
                n_in_frame = 1'b1;
                n_digits   = '0;
                n_acc      = '0;
                n_bad      = 1'b0;
            end else if (r_in_frame) begin
                priority if (i_byte == rtcc_pkg::CHAR_CLOSE) begin
                    priority if (r_bad) begin
                        o_status = rtcc_pkg::ST_BAD_INPUT;
                    end else if (six_ok) begin
                        o_status       = time_bad ? rtcc_pkg::ST_BAD_TIME
                                                  : rtcc_pkg::ST_TIME_SET;
                        o_load.time_ld = !time_bad;
                    end else if (eight_ok) begin
                        o_status       = date_bad ? rtcc_pkg::ST_BAD_DATE
                                                  : rtcc_pkg::ST_DATE_SET;
                        o_load.date_ld = !date_bad;
                    end else begin
                        o_status = rtcc_pkg::ST_BAD_INPUT;
                    end
                    n_in_frame = 1'b0;
                    n_digits   = '0;
                    n_acc      = '0;
                    n_bad      = 1'b0;
                end else if (is_digit) begin
                    if (r_digits < rtcc_pkg::DIGITS_DATE) begin
                        n_acc = {r_acc[27:0], i_byte[3:0]};
                    end
                    if (r_digits != rtcc_pkg::DIGITS_SAT) begin
                        n_digits = r_digits + 4'd1;
                    end
                end else begin
                    n_bad = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_digits   <= '0;
            r_acc      <= '0;
            r_bad      <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
            r_digits   <= n_digits;
            r_acc      <= n_acc;
            r_bad      <= n_bad;
        end
    end

    `RTCC_ASSERT_IMP(a_status_only_on_close, i_clk, i_rst_n, (o_status != rtcc_pkg::ST_NONE), (i_fire && (i_cmd == rtcc_pkg::CMD_BYTE) && (i_byte == rtcc_pkg::CHAR_CLOSE) && r_in_frame), "Status reported without a frame end.")
    `RTCC_ASSERT_IMP(a_digits_idle_outside_frame, i_clk, i_rst_n, (!r_in_frame), ((r_digits == 4'd0) && (r_acc == 32'd0) && !r_bad), "Frame counters not clear outside a frame.")

endmodule

`default_nettype wire

FILE: hdl/rtcc_clock.sv
`default_nettype none

`include "rtc_calendar_with_command_parser_defines.svh"

module rtcc_clock (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [7:0]       i_cfg_wdata,
    input  wire logic             i_fire,
    input  wire logic             i_cmd,
    input  wire rtcc_pkg::t_load  i_load,
    output rtcc_pkg::t_cal        o_next
);

    logic [7:0]     r_tps;
    logic [7:0]     r_ticks;
    rtcc_pkg::t_cal r_cal;
    logic [15:0]    r_year_bcd;

    logic [7:0]     n_ticks;
    rtcc_pkg::t_cal n_cal;
    logic [15:0]    n_year_bcd;

    logic [7:0]     tps_eff;
    logic [8:0]     tick_inc;
    logic [8:0]     tick_sub;
    logic           adv;
    logic [4:0]     mlen;

    always_comb begin
        tps_eff  = (r_tps == 8'd0) ? 8'd1 : r_tps;
        tick_inc = {1'b0, r_ticks} + 9'd1;
        tick_sub = tick_inc - {1'b0, tps_eff};
        adv      = (tick_inc >= {1'b0, tps_eff});
        mlen     = rtcc_pkg::month_len(r_cal.month, rtcc_pkg::is_leap_bcd(r_year_bcd));

        n_ticks    = r_ticks;
        n_cal      = r_cal;
        n_year_bcd = r_year_bcd;

        if (i_fire && (i_cmd == rtcc_pkg::CMD_TICK)) begin
            n_ticks = adv ? tick_sub[7:0] : tick_inc[7:0];
            if (adv) begin
                if (r_cal.sec != rtcc_pkg::SEC_MAX) begin
                    n_cal.sec = r_cal.sec + 6'd1;
                end else begin
                    n_cal.sec = '0;
                    if (r_cal.min != rtcc_pkg::MIN_MAX) begin
                        n_cal.min = r_cal.min + 6'd1;
                    end else begin
                        n_cal.min = '0;
                        if (r_cal.hour != rtcc_pkg::HOUR_MAX) begin
                            n_cal.hour = r_cal.hour + 5'd1;
                        end else begin
                            n_cal.hour = '0;
                            if (r_cal.day < mlen) begin
                                n_cal.day = r_cal.day + 5'd1;
                            end else begin
                                n_cal.day = 5'd1;
                                if (r_cal.month < rtcc_pkg::MONTH_MAX) begin
                                    n_cal.month = r_cal.month + 4'd1;
                                end else begin
                                    n_cal.month = 4'd1;
                                    if (r_cal.year >= rtcc_pkg::YEAR_MAX) begin
                                        n_cal.year = '0;
                                        n_year_bcd = '0;
                                    end else begin
                                        n_cal.year = r_cal.year + 14'd1;
                                        n_year_bcd = rtcc_pkg::bcd4_inc(r_year_bcd);
                                    end
                                end
                            end
                        end
                    end
                end
            end
        end else if (i_fire) begin
            if (i_load.time_ld) begin
                n_cal.hour = i_load.hour;
                n_cal.min  = i_load.min;
                n_cal.sec  = i_load.sec;
            end
            if (i_load.date_ld) begin
                n_cal.day   = i_load.day;
                n_cal.month = i_load.month;
                n_cal.year  = i_load.year;
                n_year_bcd  = i_load.year_bcd;
            end
        end

        o_next = n_cal;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps       <= rtcc_pkg::TPS_RESET;
            r_ticks     <= '0;
            r_cal.sec   <= rtcc_pkg::SEC_RESET;
            r_cal.min   <= rtcc_pkg::MIN_RESET;
            r_cal.hour  <= rtcc_pkg::HOUR_RESET;
            r_cal.day   <= rtcc_pkg::DAY_RESET;
            r_cal.month <= rtcc_pkg::MONTH_RESET;
            r_cal.year  <= rtcc_pkg::YEAR_RESET;
            r_year_bcd  <= rtcc_pkg::YEAR_BCD_RESET;
        end else begin
            if (i_cfg_we) begin
                r_tps <= i_cfg_wdata;
            end
            r_ticks    <= n_ticks;
            r_cal      <= n_cal;
            r_year_bcd <= n_year_bcd;
        end
    end

    `RTCC_ASSERT_IMP(a_calendar_in_range, i_clk, i_rst_n, 1'b1, ((r_cal.sec <= rtcc_pkg::SEC_MAX) && (r_cal.min <= rtcc_pkg::MIN_MAX) && (r_cal.hour <= rtcc_pkg::HOUR_MAX) && (r_cal.day != 5'd0) && (r_cal.month != 4'd0) && (r_cal.month <= rtcc_pkg::MONTH_MAX) && (r_cal.year <= rtcc_pkg::YEAR_MAX)), "Calendar field out of range.")
    `RTCC_ASSERT_IMP(a_year_copies_agree, i_clk, i_rst_n, 1'b1, (rtcc_pkg::bcd4_to_bin(r_year_bcd) == r_cal.year), "Binary and BCD year disagree.")
    `RTCC_ASSERT_NXT(a_time_load_taken, i_clk, i_rst_n, (i_fire && (i_cmd == rtcc_pkg::CMD_BYTE) && i_load.time_ld), ((r_cal.sec == $past(i_load.sec)) && (r_cal.hour == $past(i_load.hour))), "Time load not applied.")

endmodule

`default_nettype wire

FILE: hdl/rtc_calendar_with_command_parser.sv
// Calendar clock with a serial command parser.
// Input channel (s_axis): one transfer is one item. tuser bit 0 selects the
// kind: 0 is a timer tick, 1 is a received character carried in tdata.
// Every ticks_per_second ticks advance the clock by one second.
// Characters form frames [HHMMSS] or [DDMMYYYY] that set the time or date.
// Output channel (m_axis): exactly one transfer per input item, carrying the
// calendar after that item in tdata and the command status in tuser.
// The configuration port writes ticks_per_second whenever i_cfg_we is high;
// it should be written only while no item is in flight.
// An item passes the input register and then the result register on its way
// to the result transfer.
// Throughput is one item per cycle while the receiver does not stall; the
// calendar update is one pass of logic between the two registers.
// When the receiver stalls, the result register holds, then the input
// register fills, and then o_s_axis_tready falls until the result is taken.
// Reset clears both channels and sets 18:45:10 on 1 January 1971 with ten
// ticks per second.
`default_nettype none

module rtc_calendar_with_command_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        i_s_axis_tuser,   // [0] command
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [5:0] second_now, [11:6] minute_now, [16:12] hour_now,
    // [21:17] day_now, [25:22] month_now, [39:26] year_now
    output logic [39:0]      o_m_axis_tdata,
    output logic [2:0]       o_m_axis_tuser    // [2:0] status
);

    logic               r_in_valid;
    logic               r_in_cmd;
    logic [7:0]         r_in_byte;
    logic               r_out_valid;
    rtcc_pkg::t_cal     r_out_cal;
    rtcc_pkg::t_status  r_out_status;

    logic               fire;
    rtcc_pkg::t_load    load;
    rtcc_pkg::t_status  status;
    rtcc_pkg::t_cal     next_cal;

    assign fire            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || fire;

    rtcc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_cmd    (r_in_cmd),
        .i_byte   (r_in_byte),
        .o_load   (load),
        .o_status (status)
    );

    rtcc_clock u_clock (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_cmd       (r_in_cmd),
        .i_load      (load),
        .o_next      (next_cal)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_cmd  <= i_s_axis_tuser;
            r_in_byte <= i_s_axis_tdata;
        end
        if (fire) begin
            r_out_cal    <= next_cal;
            r_out_status <= status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_cal;
    assign o_m_axis_tuser  = r_out_status;

endmodule

`default_nettype wire
